// ----- sv/fit_policy_block_allocator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the block allocator
// Clocked, reset-gated property checks for the allocator core.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define FPBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define FPBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/fpba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared constants, codes and types of the fit policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 32;

  // item kinds
  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // placement rules; any other code behaves as first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // per-cell control from the sequencer
  typedef struct packed {
    logic       clear;
    logic       load;
    logic       mark;
    logic       loaded;
    logic [1:0] policy;
  } cell_ctrl_t;

endpackage

// ----- sv/fpba_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator channels
// Valid/ready channels for input items, results and the policy register.
// ----------------------------------------------------------------------------
interface fpba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] size;

  modport source (output valid, output mode, output size, input ready);
  modport sink   (input valid, input mode, input size, output ready);
endinterface

interface fpba_out_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic [3:0] block_index;
  logic [1:0] status;

  modport source (output valid, output granted, output block_index, output status,
                  input ready);
  modport sink   (input valid, input granted, input block_index, input status,
                  output ready);
endinterface

interface fpba_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] fit_policy;

  modport source (output valid, output fit_policy, input ready);
  modport sink   (input valid, input fit_policy, output ready);
endinterface

// ----- sv/fit_policy_block_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// Block table with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// The table is a row of NUM_BLOCKS cells, one block each. A clear or load
// item goes from acceptance through the response state into the output
// register. On a request a candidate word enters cell 0 and moves one cell
// per cycle down the row, each cell replacing it when its own block is a
// better fit; the word leaving the last cell names the chosen block. One
// item is worked on at a time; the next item is taken while the previous
// result still waits on the output channel. The user must write the policy
// register through the configuration channel only while idle (not enforced).
module fit_policy_block_allocator_core #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpba_in_if.sink     in_i,
  fpba_cfg_if.sink    cfg_i,
  fpba_out_if.source  out_o
);

`include "fit_policy_block_allocator_core_assert.svh"

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [SIZE_WIDTH-1:0] want_q;
  logic [1:0]            policy_q;
  logic                  start_q;
  logic                  res_granted_q;
  logic [IDX_W-1:0]      res_idx_q;
  logic [1:0]            res_status_q;
  logic                  out_valid_q;
  logic                  out_granted_q;
  logic [3:0]            out_index_q;
  logic [1:0]            out_status_q;

  logic                  in_acc;
  logic                  clear_go;
  logic                  load_go;
  logic                  scan_done;
  logic                  out_free;
  logic [SIZE_WIDTH-1:0] in_size;
  logic [IDX_W+3:0]      res_idx_ext;

  logic [NUM_BLOCKS:0]   tok;
  logic [NUM_BLOCKS:0]   found;
  logic [IDX_W-1:0]      idx  [NUM_BLOCKS+1];
  logic [SIZE_WIDTH-1:0] best [NUM_BLOCKS+1];
  fpba_pkg::cell_ctrl_t  ctrl [NUM_BLOCKS];

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_size     = in_i.size[SIZE_WIDTH-1:0];
  assign clear_go    = in_acc && (in_i.mode == fpba_pkg::MODE_CLEAR);
  assign load_go     = in_acc && (in_i.mode == fpba_pkg::MODE_LOAD) &&
                       (cnt_q < CNT_W'(NUM_BLOCKS));
  assign scan_done   = (state_q == S_SCAN) && tok[NUM_BLOCKS];
  assign out_free    = !out_valid_q || out_o.ready;
  assign res_idx_ext = {4'b0000, res_idx_q};

  assign tok[0]   = start_q;
  assign found[0] = 1'b0;
  assign idx[0]   = '0;
  assign best[0]  = '0;

  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    assign ctrl[k].clear  = clear_go;
    assign ctrl[k].load   = load_go && (cnt_q[IDX_W-1:0] == IDX_W'(k));
    assign ctrl[k].mark   = scan_done && found[NUM_BLOCKS] &&
                            (idx[NUM_BLOCKS] == IDX_W'(k));
    assign ctrl[k].loaded = (cnt_q > CNT_W'(k));
    assign ctrl[k].policy = policy_q;

    fpba_cell #(
      .SIZE_W   (SIZE_WIDTH),
      .IDX_W    (IDX_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[k]),
      .size_i  (in_size),
      .want_i  (want_q),
      .tok_i   (tok[k]),
      .found_i (found[k]),
      .idx_i   (idx[k]),
      .best_i  (best[k]),
      .tok_o   (tok[k+1]),
      .found_o (found[k+1]),
      .idx_o   (idx[k+1]),
      .best_o  (best[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      want_q <= in_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      policy_q      <= fpba_pkg::POL_FIRST;
      start_q       <= 1'b0;
      res_granted_q <= 1'b0;
      res_idx_q     <= '0;
      res_status_q  <= fpba_pkg::ST_DONE;
      out_valid_q   <= 1'b0;
      out_granted_q <= 1'b0;
      out_index_q   <= '0;
      out_status_q  <= fpba_pkg::ST_DONE;
    end else begin
      start_q <= in_acc && (in_i.mode == fpba_pkg::MODE_REQUEST);
      if (cfg_i.valid) begin
        policy_q <= cfg_i.fit_policy;
      end
      if (out_valid_q && out_o.ready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_granted_q <= 1'b0;
            res_idx_q     <= '0;
            case (in_i.mode)
              fpba_pkg::MODE_CLEAR: begin
                cnt_q        <= '0;
                res_status_q <= fpba_pkg::ST_DONE;
                state_q      <= S_RESP;
              end
              fpba_pkg::MODE_LOAD: begin
                state_q <= S_RESP;
                if (load_go) begin
                  cnt_q        <= cnt_q + CNT_W'(1);
                  res_status_q <= fpba_pkg::ST_DONE;
                end else begin
                  res_status_q <= fpba_pkg::ST_FULL;
                end
              end
              fpba_pkg::MODE_REQUEST: begin
                res_status_q <= fpba_pkg::ST_DONE;
                state_q      <= S_SCAN;
              end
              default: begin
                res_status_q <= fpba_pkg::ST_DONE;
                state_q      <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            res_granted_q <= found[NUM_BLOCKS];
            res_idx_q     <= found[NUM_BLOCKS] ? idx[NUM_BLOCKS] : '0;
            res_status_q  <= found[NUM_BLOCKS] ? fpba_pkg::ST_DONE : fpba_pkg::ST_NOFIT;
            state_q       <= S_RESP;
          end
        end
        S_RESP: begin
          // hold until the output register frees up
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_granted_q <= res_granted_q;
            out_index_q   <= res_idx_ext[3:0];
            out_status_q  <= res_status_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.granted     = out_granted_q;
  assign out_o.block_index = out_index_q;
  assign out_o.status      = out_status_q;

  `FPBA_ASSERT(a_cnt_range, cnt_q <= CNT_W'(NUM_BLOCKS), "block count beyond table depth")
  `FPBA_ASSERT(a_one_word, $onehot0(tok), "more than one candidate word in the row")
  `FPBA_ASSERT_IMP(a_idle_row, state_q == S_IDLE, tok == '0, "candidate word while idle")
  `FPBA_ASSERT_IMP(a_grant_ok, res_granted_q, res_status_q == fpba_pkg::ST_DONE, "grant with fail status")

endmodule

// ----- sv/fpba_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_cell
// One table entry: holds a block size and its used mark, and updates the
// candidate word that walks past it during a request scan.
// ----------------------------------------------------------------------------
module fpba_cell #(
  parameter int SIZE_W   = fpba_pkg::SIZE_WIDTH_DEF,
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpba_pkg::cell_ctrl_t ctrl_i,
  input  logic [SIZE_W-1:0]   size_i,
  input  logic [SIZE_W-1:0]   want_i,
  input  logic                tok_i,
  input  logic                found_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic [SIZE_W-1:0]   best_i,
  output logic                tok_o,
  output logic                found_o,
  output logic [IDX_W-1:0]    idx_o,
  output logic [SIZE_W-1:0]   best_o
);

  logic [SIZE_W-1:0] size_q;
  logic              used_q;
  logic              tok_q;
  logic              found_q;
  logic [IDX_W-1:0]  idx_q;
  logic [SIZE_W-1:0] best_q;
  logic              eligible;
  logic              take;

  assign eligible = ctrl_i.loaded && !used_q && (size_q >= want_i);
  assign take = eligible &&
                (!found_i ||
                 ((ctrl_i.policy == fpba_pkg::POL_BEST)  && (size_q < best_i)) ||
                 ((ctrl_i.policy == fpba_pkg::POL_WORST) && (size_q > best_i)));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      size_q <= size_i;
    end
    if (tok_i) begin
      idx_q  <= take ? IDX_W'(CELL_IDX) : idx_i;
      best_q <= take ? size_q : best_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      tok_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (ctrl_i.clear || ctrl_i.load) begin
        used_q <= 1'b0;
      end else if (ctrl_i.mark) begin
        used_q <= 1'b1;
      end
      // pass the candidate word one cell per cycle
      tok_q <= tok_i;
      if (tok_i) begin
        found_q <= found_i || take;
      end
    end
  end

  assign tok_o   = tok_q;
  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign best_o  = best_q;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fit policy block allocator. Directed items hit
// the empty table, the full table, the value extremes and every placement
// rule. Random load and request bursts follow, each under a newly written
// policy. Both channel ends idle at random. A long result stall backs the
// block up. Every result word is checked against a table model kept in
// step with each accepted input word.
// ----------------------------------------------------------------------------
module tb_top;
  import fpba_pkg::*;

  localparam int          N_BLOCKS      = NUM_BLOCKS_DEF;
  localparam int unsigned RANDOM_ITEMS  = 870;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam logic [1:0]  MODE_IGNORED  = 2'd3;  // spare item kind, no effect
  localparam logic [1:0]  POL_SPARE     = 2'd3;  // spare rule, behaves as first fit

  typedef struct packed {
    logic       granted;
    logic [3:0] block_index;
    logic [1:0] status;
  } alloc_result_t;

  logic clk_i;
  logic rst_ni;

  fpba_in_if  req_ch ();
  fpba_out_if res_ch ();
  fpba_cfg_if cfg_ch ();

  fit_policy_block_allocator_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .cfg_i  (cfg_ch),
    .out_o  (res_ch)
  );

  // table model
  logic [31:0]   tbl_size [N_BLOCKS];
  bit            tbl_used [N_BLOCKS];
  int unsigned   tbl_count;
  logic [1:0]    cur_policy;

  alloc_result_t pending_results [$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  bit            idle_on;
  int unsigned   hold_off_cycles;

  logic [31:0] preset_sizes [N_BLOCKS] = '{
    32'd9, 32'hFFFF_FFFF, 32'd4, 32'd6, 32'd0, 32'd6, 32'h8000_0000, 32'd1,
    32'd2, 32'd5, 32'd6, 32'd8, 32'd3, 32'd7, 32'd10, 32'h7FFF_FFFF
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one word to the table model and return the result it yields.
  function automatic alloc_result_t alloc_step(input logic [1:0] mode,
                                               input logic [31:0] item_size);
    alloc_result_t r;
    int            pick;
    logic [31:0]   pick_size;
    r.granted     = 1'b0;
    r.block_index = 4'd0;
    r.status      = ST_DONE;
    pick          = -1;
    pick_size     = '0;
    case (mode)
      MODE_CLEAR: begin
        tbl_count = 0;
        foreach (tbl_used[k]) tbl_used[k] = 1'b0;
      end
      MODE_LOAD: begin
        if (tbl_count >= N_BLOCKS) begin
          r.status = ST_FULL;
        end else begin
          tbl_size[tbl_count] = item_size;
          tbl_used[tbl_count] = 1'b0;
          tbl_count++;
        end
      end
      MODE_REQUEST: begin
        for (int k = 0; k < tbl_count; k++) begin
          if (tbl_used[k] || tbl_size[k] < item_size) continue;
          if (pick < 0) begin
            pick      = k;
            pick_size = tbl_size[k];
            if (cur_policy != POL_BEST && cur_policy != POL_WORST) break;
          end else if (cur_policy == POL_BEST && tbl_size[k] < pick_size) begin
            pick      = k;
            pick_size = tbl_size[k];
          end else if (cur_policy == POL_WORST && tbl_size[k] > pick_size) begin
            pick      = k;
            pick_size = tbl_size[k];
          end
        end
        if (pick < 0) begin
          r.status = ST_NOFIT;
        end else begin
          tbl_used[pick] = 1'b1;
          r.granted      = 1'b1;
          r.block_index  = 4'(pick);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Call at a rising edge; returns at the edge that accepted the word with
  // valid still high, so the caller sends again or lowers it in that step.
  task automatic send_item(input logic [1:0] mode, input logic [31:0] item_size);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.size  <= item_size;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_results.push_back(alloc_step(mode, item_size));
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_fit_policy(input logic [1:0] policy);
    drain_results();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.fit_policy <= policy;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_policy = policy;
  endtask

  function automatic logic [31:0] draw_size(input int unsigned domain);
    int unsigned d;
    d = (domain > 2) ? $urandom_range(0, 2) : domain;
    case (d)
      0: return 32'($urandom_range(0, 15));  // narrow range: ties and exact fits
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'd0;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          4: return 32'd1;
          default: return 32'hFFFF_FFFE;
        endcase
      end
    endcase
  endfunction

  task automatic test_empty_table();
    send_item(MODE_REQUEST, 32'd0);
    send_item(MODE_IGNORED, 32'hFFFF_FFFF);
    send_item(MODE_CLEAR, 32'hFFFF_FFFF);
  endtask

  task automatic test_table_full();
    set_fit_policy(POL_FIRST);
    send_item(MODE_CLEAR, 32'd0);
    for (int k = 0; k < N_BLOCKS; k++) send_item(MODE_LOAD, preset_sizes[k]);
    send_item(MODE_LOAD, 32'd1);
  endtask

  task automatic test_fit_policies();
    send_item(MODE_REQUEST, 32'd5);
    set_fit_policy(POL_BEST);
    send_item(MODE_REQUEST, 32'd6);
    set_fit_policy(POL_WORST);
    send_item(MODE_REQUEST, 32'd0);
    send_item(MODE_REQUEST, 32'hFFFF_FFFF);
    set_fit_policy(POL_SPARE);
    send_item(MODE_REQUEST, 32'd0);
  endtask

  // Stall the result side long enough that the block backs up its input.
  task automatic test_output_backpressure();
    drain_results();
    idle_on         = 1'b0;
    hold_off_cycles = 150;
    send_item(MODE_CLEAR, 32'd0);
    repeat (6) send_item(MODE_LOAD, draw_size(0));
    repeat (5) send_item(MODE_REQUEST, draw_size(0));
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned domain;
    int unsigned n_load;
    int unsigned n_req;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_fit_policy(2'($urandom_range(0, 3)));
      idle_on = ($urandom_range(0, 3) != 0);
      domain  = $urandom_range(0, 3);
      // mostly a clear, a fill and a run of requests; now and then a broken one
      if ($urandom_range(0, 9) != 0) begin
        send_item(MODE_CLEAR, $urandom);
        sent++;
      end
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      repeat (n_load) begin
        send_item(MODE_LOAD, draw_size(domain));
        sent++;
      end
      n_req = $urandom_range(1, 20);
      repeat (n_req) begin
        case ($urandom_range(0, 19))
          0: send_item(MODE_IGNORED, $urandom);
          1: begin
            send_item(MODE_LOAD, draw_size(domain));
            sent++;
          end
          2: begin
            send_item(MODE_CLEAR, $urandom);
            sent++;
          end
          default: begin
            send_item(MODE_REQUEST, draw_size(domain));
            sent++;
          end
        endcase
      end
    end
  endtask

  // result side: per word draw a stall, or take a requested long hold-off
  initial begin : result_ready
    int unsigned stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 16) : 0;
      if (hold_off_cycles != 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
    end
  end

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d", $time,
                 res_ch.granted, res_ch.block_index, res_ch.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("granted", want.granted, res_ch.granted);
        check_field("block_index", want.block_index, res_ch.block_index);
        check_field("status", want.status, res_ch.status);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    error_count     = 0;
    cycle_count     = 0;
    idle_on         = 1'b1;
    hold_off_cycles = 0;
    tbl_count       = 0;
    cur_policy      = POL_FIRST;
    foreach (tbl_used[k]) tbl_used[k] = 1'b0;
    foreach (tbl_size[k]) tbl_size[k] = '0;
    rst_ni            <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_CLEAR;
    req_ch.size       <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.fit_policy <= POL_FIRST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_table_full();
    test_fit_policies();
    test_output_backpressure();
    test_random_sequences();

    drain_results();
    repeat (N_BLOCKS + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fpba_pkg.sv
sv/fpba_if.sv
sv/fpba_cell.sv
sv/fit_policy_block_allocator_core.sv
sim/tb_top.sv
